/* src/psev_pkg.sv */
// psev_pkg: shared types, codes and widths for the postfix stack evaluator
// used by the channel interfaces and every module of the block

package psev_pkg;

    // field widths
    localparam int FUNC_W   = 3;
    localparam int DIGIT_W  = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // default operand stack depth
    localparam int STACK_DEPTH_DEF = 32;

    // token queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // iterative divider, one quotient bit per cycle
    localparam int DIV_STEPS = VALUE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // token function codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // value for an empty pop and for an errored expression
    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

    // token class decided by the front end
    typedef enum logic [2:0] {
        K_PUSH,
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_NOP
    } t_kind;

    // classified token as it sits in the queue
    typedef struct packed {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_tok;

    // back end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_FIN
    } t_back_state;

endpackage

/* src/psev_ifs.sv */
// psev_ifs: valid/ready channel interfaces for tokens and results
// depends on psev_pkg for field widths

interface psev_tok_if import psev_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [DIGIT_W-1:0] digit;
    logic               last;

    modport source (output valid, output func, output digit, output last, input ready);
    modport sink   (input valid, input func, input digit, input last, output ready);
endinterface

interface psev_res_if import psev_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

/* src/psev_front.sv */
// psev_front: token intake, classification and the short token queue
// depends on psev_pkg and psev_tok_if

module psev_front import psev_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psev_tok_if.sink    i_tok,
    output t_tok        o_q_tok,
    output logic        o_q_valid,
    input  logic        i_q_pop
);

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_tok              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_fill, n_fill;

    t_kind kind;
    t_tok  tok_in;
    logic  push;
    logic  pop;

    // classify the function code
    always_comb begin
        case (i_tok.func)
            FUNC_PUSH: kind = K_PUSH;
            FUNC_ADD:  kind = K_ADD;
            FUNC_SUB:  kind = K_SUB;
            FUNC_MUL:  kind = K_MUL;
            FUNC_DIV:  kind = K_DIV;
            default:   kind = K_NOP;
        endcase
    end

    assign tok_in.kind  = kind;
    assign tok_in.digit = i_tok.digit;
    assign tok_in.last  = i_tok.last;

    // handshakes on both sides of the queue
    assign i_tok.ready = (r_fill != QCNT_W'(QUEUE_DEPTH));
    assign push        = i_tok.valid && i_tok.ready;
    assign o_q_valid   = (r_fill != '0);
    assign pop         = i_q_pop && o_q_valid;
    assign o_q_tok     = r_q[r_rd_ptr];

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_fill = r_fill + QCNT_W'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= tok_in;
        end
    end

endmodule

/* src/psev_div.sv */
// psev_div: iterative signed divider, truncating toward zero, one bit per cycle
// depends on psev_pkg

module psev_div import psev_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_dividend,
    input  logic [VALUE_W-1:0] i_divisor,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_W:0]     r_rem, n_rem;
    logic [VALUE_W-1:0]   r_quo, n_quo;
    logic [VALUE_W-1:0]   r_dvs, n_dvs;
    logic                 r_neg, n_neg;

    logic [VALUE_W:0]     rem_sh;
    logic [VALUE_W:0]     diff;

    // restoring step on magnitudes
    assign rem_sh = {r_rem[VALUE_W-1:0], r_quo[VALUE_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend[VALUE_W-1] ? (VALUE_W'(0) - i_dividend) : i_dividend;
            n_dvs  = i_divisor[VALUE_W-1] ? (VALUE_W'(0) - i_divisor) : i_divisor;
            n_neg  = i_dividend[VALUE_W-1] ^ i_divisor[VALUE_W-1];
        end else if (r_busy) begin
            if (!diff[VALUE_W]) begin
                n_rem = diff;
                n_quo = {r_quo[VALUE_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[VALUE_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    // sign fix-up; the most negative over minus one wraps by itself
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (VALUE_W'(0) - r_quo) : r_quo;

endmodule

/* src/psev_back.sv */
// psev_back: operand stack memory, token sequencer and result register
// depends on psev_pkg and psev_res_if; drives psev_div

module psev_back import psev_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tok               i_q_tok,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    output logic               o_div_start,
    output logic [VALUE_W-1:0] o_div_dividend,
    output logic [VALUE_W-1:0] o_div_divisor,
    input  logic               i_div_done,
    input  logic [VALUE_W-1:0] i_div_quotient,
    psev_res_if.source         o_res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // operand stack
    logic [VALUE_W-1:0] r_stack [STACK_DEPTH];
    logic [VALUE_W-1:0] r_rd_a, r_rd_b;

    t_back_state         r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [STATUS_W-1:0] r_err, n_err;
    t_tok                r_tok, n_tok;
    logic [VALUE_W-1:0]  r_res, n_res;
    logic                r_use_res, n_use_res;
    logic                r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic               rd_en;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [CW-1:0]      cnt_m1, cnt_m2;
    logic [VALUE_W-1:0] op_a, op_b;
    logic               out_free;

    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);
    assign out_free = !r_out_valid || o_res.ready;

    // operands of the registered reads, an empty slot reads as all ones
    assign op_b = (r_count >= CW'(1)) ? r_rd_b : EMPTY_VALUE;
    assign op_a = (r_count >= CW'(2)) ? r_rd_a : EMPTY_VALUE;

    assign o_div_dividend = op_a;
    assign o_div_divisor  = op_b;

    // sequencer next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_err        = r_err;
        n_tok        = r_tok;
        n_res        = r_res;
        n_use_res    = r_use_res;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        o_q_pop      = 1'b0;
        o_div_start  = 1'b0;
        rd_en        = 1'b0;
        we           = 1'b0;
        waddr        = r_count[AW-1:0];
        wdata        = r_res;

        // result taken downstream
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    n_tok     = i_q_tok;
                    rd_en     = 1'b1;
                    n_use_res = 1'b0;
                    n_state   = i_q_tok.last ? S_FIN : S_IDLE;
                    if (r_err == ST_OK) begin
                        case (i_q_tok.kind)
                            K_PUSH: begin
                                if (r_count == DEPTH_C) begin
                                    n_err = ST_OVERFLOW;
                                end else begin
                                    we        = 1'b1;
                                    wdata     = {{(VALUE_W-DIGIT_W){1'b0}}, i_q_tok.digit};
                                    n_count   = r_count + CW'(1);
                                    n_res     = wdata;
                                    n_use_res = 1'b1;
                                end
                            end
                            K_ADD, K_SUB, K_MUL, K_DIV: begin
                                n_state = S_EXEC;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            S_EXEC: begin
                n_count = (r_count >= CW'(2)) ? cnt_m2 : '0;
                n_state = S_PUSH;
                case (r_tok.kind)
                    K_ADD:   n_res = op_a + op_b;
                    K_SUB:   n_res = op_a - op_b;
                    K_MUL:   n_res = op_a * op_b;
                    K_DIV: begin
                        if (op_b == '0) begin
                            n_err   = ST_DIVZERO;
                            n_state = r_tok.last ? S_FIN : S_IDLE;
                        end else begin
                            o_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            S_DIV: begin
                if (i_div_done) begin
                    n_res   = i_div_quotient;
                    n_state = S_PUSH;
                end
            end

            S_PUSH: begin
                // never full here: the operator step left at most depth minus two entries
                we        = 1'b1;
                n_count   = r_count + CW'(1);
                n_use_res = 1'b1;
                n_state   = r_tok.last ? S_FIN : S_IDLE;
            end

            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_err != ST_OK) begin
                        n_out_value  = EMPTY_VALUE;
                        n_out_status = r_err;
                    end else begin
                        n_out_status = ST_OK;
                        if (r_use_res) begin
                            n_out_value = r_res;
                        end else if (r_count != '0) begin
                            n_out_value = r_rd_b;
                        end else begin
                            n_out_value = EMPTY_VALUE;
                        end
                    end
                    n_count = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tok        <= n_tok;
        r_res        <= n_res;
        r_use_res    <= n_use_res;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_stack[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_b <= r_stack[cnt_m1[AW-1:0]];
            r_rd_a <= r_stack[cnt_m2[AW-1:0]];
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_out_value;
    assign o_res.status = r_out_status;

endmodule

/* src/postfix_stack_evaluator.sv */
// postfix_stack_evaluator: top level, front end, token queue, back end, divider
// depends on psev_pkg, psev_ifs, psev_front, psev_back, psev_div
//
//   channel   dir  width (payload)                  handshake
//   i_tok     in   func 3, digit 4, last 1          valid/ready
//   o_res     out  value 32 signed, status 2        valid/ready
//
// the front end takes a token per cycle while its two-entry queue has room
// back end: a push or no-op token is taken in the idle state; add/sub/mul go through read,
// compute and write steps on the single-write stack memory; divide waits on the 32-step divider
// a last token adds a final step that loads the result register
// reset is synchronous, active low; the stack memory needs no clearing pass
// a stalled result holds the back end in its final step; the queue keeps filling

module postfix_stack_evaluator import psev_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psev_tok_if.sink    i_tok,
    psev_res_if.source  o_res
);

    t_tok               q_tok;
    logic               q_valid;
    logic               q_pop;
    logic               div_start;
    logic [VALUE_W-1:0] div_dividend;
    logic [VALUE_W-1:0] div_divisor;
    logic               div_done;
    logic [VALUE_W-1:0] div_quotient;

    // token intake and queue
    psev_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tok     (i_tok),
        .o_q_tok   (q_tok),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop)
    );

    // stack execution
    psev_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_tok        (q_tok),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quotient (div_quotient),
        .o_res          (o_res)
    );

    // iterative divider
    psev_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

endmodule
